[rtl/core/sst_pkg.sv]
package sst_pkg;

  // Fixed field widths of the item ports.
  localparam int OP_W      = 2;
  localparam int KEY_W     = 10;
  localparam int IDX_IN_W  = 8;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 9;

  // Operation codes carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_READ_SLOT = 2'd3
  } op_e;

  // Status codes returned with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_PRESENT = 3'd1,
    STS_ABSENT  = 3'd2,
    STS_FULL    = 3'd3,
    STS_RANGE   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic rd_slot;
    logic exec;
  } sst_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sst_sts_t;

endpackage

[rtl/core/sst_ctrl.sv]
module sst_ctrl import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sst_sts_t sts_i,
  output sst_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_SLOT,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   stall_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o.clear_wr = (state_q == S_CLEAR);
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i && !stall_q;
    cmd_o.rd_slot  = (state_q == S_RD_SLOT);
    cmd_o.exec     = (state_q == S_EXEC) && !sts_i.out_busy;
  end

  assign in_stall_o = stall_q;

  // Sequencer: clear the id map after reset, then one item per pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      stall_q <= 1'b1;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid_i && !stall_q) begin
            state_q <= S_RD_SLOT;
            stall_q <= 1'b1;
          end
        end
        S_RD_SLOT: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_CLEAR;
          stall_q <= 1'b1;
        end
      endcase
    end
  end

  // An accepted item always moves on to the slot read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_RD_SLOT) && stall_q)
    else $error("accepted item did not advance to slot read");

  // The slot read is followed by execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_SLOT) |=> (state_q == S_EXEC))
    else $error("slot read not followed by execute");

  // Execution never overwrites a result that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !sts_i.out_busy)
    else $error("execute while output register is busy");

endmodule

[rtl/core/sst_datapath.sv]
module sst_datapath import sst_pkg::*; #(
  parameter int ID_SPACE   = 1024,
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sst_cmd_t             cmd_i,
  output sst_sts_t             sts_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [KEY_W-1:0]     key_id_i,
  input  logic [IDX_IN_W-1:0]  slot_index_i,
  input  logic [VAL_W-1:0]     entry_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [KEY_W-1:0]     result_id_o,
  output logic [IDX_IN_W-1:0]  result_slot_o,
  output logic [VAL_W-1:0]     result_value_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam int IDX_W  = $clog2(ID_SPACE);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Storage: id to slot map, slot back-pointers and slot data.
  logic [SLOT_W-1:0]     id_to_slot_mem [ID_SPACE];
  logic [KEY_W-1:0]      slot_to_id_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] slot_data_mem  [CAPACITY];

  // Latched item and read results.
  op_e                   op_q;
  logic [KEY_W-1:0]      key_q;
  logic [IDX_IN_W-1:0]   idx_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [SLOT_W-1:0]     map_q;
  logic [KEY_W-1:0]      sid_q;
  logic [DATA_WIDTH-1:0] sdat_q;
  logic [KEY_W-1:0]      lid_q;
  logic [DATA_WIDTH-1:0] ldat_q;

  // Control state.
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      clr_q;
  logic                  out_valid_q;

  // Result registers.
  status_e               out_status_q;
  logic [KEY_W-1:0]      out_id_q;
  logic [IDX_IN_W-1:0]   out_slot_q;
  logic [VAL_W-1:0]      out_val_q;
  logic [CNT_OUT_W-1:0]  out_count_q;

  // Decision signals.
  logic [SLOT_W-1:0]     slot_a;
  logic [SLOT_W-1:0]     last_a;
  logic                  key_ok, hit, slot_ok, full;
  status_e               res_status;
  logic [KEY_W-1:0]      res_id;
  logic [IDX_IN_W-1:0]   res_slot;
  logic [DATA_WIDTH-1:0] res_val;
  logic                  wr_map_en, wr_slot_en;
  logic [IDX_W-1:0]      wr_map_addr;
  logic [SLOT_W-1:0]     wr_map_data;
  logic [SLOT_W-1:0]     wr_slot_addr;
  logic [KEY_W-1:0]      wr_slot_id;
  logic [DATA_WIDTH-1:0] wr_slot_data;

  assign sts_o.clear_last = (clr_q == IDX_W'(ID_SPACE - 1));
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // Slot read addresses: the mapped or requested slot, and the last live slot.
  assign slot_a = (op_q == OP_READ_SLOT) ? SLOT_W'(idx_q) : map_q;
  assign last_a = SLOT_W'(count_q - CNT_W'(1));

  // Presence is the map pointing below the count at a slot that points back.
  assign key_ok  = (32'(key_q) < 32'(ID_SPACE));
  assign hit     = key_ok && (32'(map_q) < 32'(count_q)) && (sid_q == key_q);
  assign slot_ok = (32'(idx_q) < 32'(count_q));
  assign full    = (32'(count_q) >= 32'(CAPACITY));

  // Result and update decision for the current item.
  always_comb begin
    res_status   = STS_ABSENT;
    res_id       = key_q;
    res_slot     = '0;
    res_val      = '0;
    count_d      = count_q;
    wr_map_en    = 1'b0;
    wr_slot_en   = 1'b0;
    wr_map_addr  = IDX_W'(key_q);
    wr_map_data  = SLOT_W'(count_q);
    wr_slot_addr = SLOT_W'(count_q);
    wr_slot_id   = key_q;
    wr_slot_data = val_q;
    case (op_q)
      OP_INSERT: begin
        if (!key_ok) begin
          res_status = STS_ABSENT;
        end else if (hit) begin
          res_status = STS_PRESENT;
          res_slot   = IDX_IN_W'(map_q);
          res_val    = sdat_q;
        end else if (full) begin
          res_status = STS_FULL;
        end else begin
          res_status = STS_OK;
          res_slot   = IDX_IN_W'(count_q);
          res_val    = val_q;
          wr_map_en  = 1'b1;
          wr_slot_en = 1'b1;
          count_d    = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          res_status   = STS_OK;
          res_slot     = IDX_IN_W'(map_q);
          res_val      = sdat_q;
          wr_slot_en   = 1'b1;
          wr_slot_addr = map_q;
          wr_slot_id   = lid_q;
          wr_slot_data = ldat_q;
          wr_map_en    = 1'b1;
          wr_map_addr  = IDX_W'(lid_q);
          wr_map_data  = map_q;
          count_d      = count_q - CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res_status = STS_OK;
          res_slot   = IDX_IN_W'(map_q);
          res_val    = sdat_q;
        end
      end
      OP_READ_SLOT: begin
        res_slot = idx_q;
        if (slot_ok) begin
          res_status = STS_OK;
          res_id     = sid_q;
          res_val    = sdat_q;
        end else begin
          res_status = STS_RANGE;
          res_id     = '0;
        end
      end
      default: begin
        res_status = STS_ABSENT;
      end
    endcase
  end

  // Id map memory: clearing pass, then at most one write per executed item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      id_to_slot_mem[clr_q] <= '0;
    end else if (cmd_i.exec && wr_map_en) begin
      id_to_slot_mem[wr_map_addr] <= wr_map_data;
    end
    if (cmd_i.accept) begin
      map_q <= id_to_slot_mem[IDX_W'(key_id_i)];
    end
  end

  // Slot memories: two slots read before execution, at most one write at execution.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_slot_en) begin
      slot_to_id_mem[wr_slot_addr] <= wr_slot_id;
      slot_data_mem[wr_slot_addr]  <= wr_slot_data;
    end
    if (cmd_i.rd_slot) begin
      sid_q  <= slot_to_id_mem[slot_a];
      sdat_q <= slot_data_mem[slot_a];
      lid_q  <= slot_to_id_mem[last_a];
      ldat_q <= slot_data_mem[last_a];
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(op_i);
      key_q <= key_id_i;
      idx_q <= slot_index_i;
      val_q <= DATA_WIDTH'(entry_value_i);
    end
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_slot_q   <= res_slot;
      out_val_q    <= VAL_W'(res_val);
      out_count_q  <= CNT_OUT_W'(count_d);
    end
  end

  // Entry count, clear counter and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_wr && !sts_o.clear_last) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_id_o    = out_id_q;
  assign result_slot_o  = out_slot_q;
  assign result_value_o = out_val_q;
  assign entry_count_o  = out_count_q;

  // Every executed item presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("executed item did not produce a result");

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY))
    else $error("entry count beyond capacity");

  // The count changes only when an item executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.exec) |-> $stable(count_q))
    else $error("entry count changed without an executed item");

endmodule

[rtl/core/sparse_set_table_core.sv]
// Sparse set table: keeps up to CAPACITY entries, each an id with a data
// word, densely packed in slots, with a map from id to slot.
// Input channel: in_valid_i / in_stall_o carry op_i, key_id_i, slot_index_i
// and entry_value_i. Ops are insert, remove, lookup by id and read by slot.
// Output channel: out_valid_o / out_stall_i carry status_o, result_id_o,
// result_slot_o, result_value_o and entry_count_o, one result per item.
// Each item passes through the idle, slot-read and execute states: the id
// map is read as the item is accepted, the back-pointer and data reads
// (mapped slot and last live slot) follow in the slot-read state, and the
// execute state decides, writes the memories for an insert or remove and
// loads the output register. A new item is taken only back in idle.
// The output register lets the next item be accepted while a result waits;
// if the receiver still stalls when the next result is ready, execution
// holds and the input channel stays stalled until the output is taken.
// After reset the id map is cleared, one entry per cycle, through all ID_SPACE
// entries; in_stall_o stays high during that pass and the table is empty.
module sparse_set_table_core import sst_pkg::*; #(
  parameter int ID_SPACE   = 1024,
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [KEY_W-1:0]     key_id_i,
  input  logic [IDX_IN_W-1:0]  slot_index_i,
  input  logic [VAL_W-1:0]     entry_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [KEY_W-1:0]     result_id_o,
  output logic [IDX_IN_W-1:0]  result_slot_o,
  output logic [VAL_W-1:0]     result_value_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  // Sequencer.
  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Memories, item registers and result logic.
  sst_datapath #(
    .ID_SPACE   (ID_SPACE),
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .key_id_i       (key_id_i),
    .slot_index_i   (slot_index_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .result_slot_o  (result_slot_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

[dv/testbench.sv]
module testbench;
  import sst_pkg::*;

  localparam int ID_SPACE       = 1024;
  localparam int CAPACITY       = 256;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int SEGMENT_LEN    = 150;
  localparam int PACE_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;

  // One result item as the block reports it.
  typedef struct packed {
    status_e                status;
    logic [KEY_W-1:0]       id;
    logic [IDX_IN_W-1:0]    slot;
    logic [VAL_W-1:0]       value;
    logic [CNT_OUT_W-1:0]   count;
  } table_result_t;

  // One row of the directed script; typed rows carry their own answer.
  typedef struct packed {
    op_e                 op;
    logic [KEY_W-1:0]    key;
    logic [IDX_IN_W-1:0] idx;
    logic [VAL_W-1:0]    value;
    logic                typed;
    table_result_t       answer;
  } script_row_t;

  // Operation mix of the random traffic.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_BALANCED,
    MIX_SHRINK
  } traffic_mix_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  op_e                  op_in = OP_LOOKUP;
  logic [KEY_W-1:0]     key_in = '0;
  logic [IDX_IN_W-1:0]  idx_in = '0;
  logic [VAL_W-1:0]     value_in = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [KEY_W-1:0]     result_id_o;
  logic [IDX_IN_W-1:0]  result_slot_o;
  logic [VAL_W-1:0]     result_value_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Expected answers in flight, and the answer typed for the item on the bus.
  table_result_t        pending[$];
  logic                 drive_typed = 1'b0;
  table_result_t        drive_answer = '0;
  int                   errors = 0;
  int                   items_sent = 0;
  int                   gap_pct = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;

  // Shadow copy of the table contents.
  logic [IDX_IN_W-1:0]  map_slot [ID_SPACE];
  logic [KEY_W-1:0]     slot_key [CAPACITY];
  logic [VAL_W-1:0]     slot_word [CAPACITY];
  int unsigned          live_entries = 0;

  sparse_set_table_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .op_i           (op_in),
    .key_id_i       (key_in),
    .slot_index_i   (idx_in),
    .entry_value_i  (value_in),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .result_slot_o  (result_slot_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the shadow table and return the answer it gives.
  function automatic table_result_t apply_to_table(input op_e op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [IDX_IN_W-1:0] idx,
                                                   input logic [VAL_W-1:0] value);
    table_result_t r;
    int unsigned   s;
    int unsigned   last;
    logic          found;
    logic [KEY_W-1:0] moved;
    r = '0;
    r.status = STS_ABSENT;
    r.id = key;
    s = map_slot[key];
    found = 1'b0;
    // An id counts as present only if its back-pointer agrees.
    if (s < live_entries) found = (slot_key[s] == key);
    case (op)
      OP_INSERT: begin
        if (found) begin
          r.status = STS_PRESENT;
          r.slot = IDX_IN_W'(s);
          r.value = slot_word[s];
        end else if (live_entries >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          s = live_entries;
          map_slot[key] = IDX_IN_W'(s);
          slot_key[s] = key;
          slot_word[s] = value;
          live_entries++;
          r.status = STS_OK;
          r.slot = IDX_IN_W'(s);
          r.value = value;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          r.status = STS_OK;
          r.slot = IDX_IN_W'(s);
          r.value = slot_word[s];
          // The last entry fills the hole and its map entry follows it.
          last = live_entries - 1;
          moved = slot_key[last];
          slot_word[s] = slot_word[last];
          slot_key[s] = moved;
          map_slot[moved] = IDX_IN_W'(s);
          live_entries = last;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          r.status = STS_OK;
          r.slot = IDX_IN_W'(s);
          r.value = slot_word[s];
        end
      end
      default: begin
        r.slot = idx;
        if (idx >= live_entries) begin
          r.status = STS_RANGE;
          r.id = '0;
        end else begin
          r.status = STS_OK;
          r.id = slot_key[idx];
          r.value = slot_word[idx];
        end
      end
    endcase
    r.count = CNT_OUT_W'(live_entries);
    return r;
  endfunction

  function automatic script_row_t script_row(input op_e op, input int key, input int idx,
                                             input logic [VAL_W-1:0] value,
                                             input logic typed = 1'b0,
                                             input status_e status = STS_OK,
                                             input int id = 0, input int slot = 0,
                                             input logic [VAL_W-1:0] result = '0,
                                             input int count = 0);
    script_row_t row;
    row.op = op;
    row.key = KEY_W'(key);
    row.idx = IDX_IN_W'(idx);
    row.value = value;
    row.typed = typed;
    row.answer.status = status;
    row.answer.id = KEY_W'(id);
    row.answer.slot = IDX_IN_W'(slot);
    row.answer.value = result;
    row.answer.count = CNT_OUT_W'(count);
    return row;
  endfunction

  // Pick an id: often one that is live, sometimes an extreme, else anything.
  function automatic logic [KEY_W-1:0] pick_key(input int live_pct);
    int r;
    r = $urandom_range(99);
    if (live_entries != 0 && r < live_pct) return slot_key[$urandom_range(live_entries - 1)];
    if (r >= 95) return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
    return KEY_W'($urandom_range(ID_SPACE - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return $urandom;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
      errors++;
    end
  endfunction

  // Present one item from a falling edge until it is accepted, then return at
  // the next falling edge. The pace of both sides changes every PACE_LEN items.
  task automatic drive_item(input op_e op, input logic [KEY_W-1:0] key,
                            input logic [IDX_IN_W-1:0] idx, input logic [VAL_W-1:0] value,
                            input logic typed, input table_result_t answer);
    case ((items_sent / PACE_LEN) % 5)
      1: begin gap_pct = 62; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 62; end
      3: begin gap_pct = 11; stall_pct = 11; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op_in = op;
    key_in = key;
    idx_in = idx;
    value_in = value;
    drive_typed = typed;
    drive_answer = answer;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stalls at random, decided at each falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Track accepted items on both channels and check every result.
  always @(posedge clk) begin : monitor
    table_result_t want;
    table_result_t predicted;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = pending.pop_front();
          compare_field("status", 32'(want.status), 32'(status_o));
          compare_field("result_id", 32'(want.id), 32'(result_id_o));
          compare_field("result_slot", 32'(want.slot), 32'(result_slot_o));
          compare_field("result_value", want.value, result_value_o);
          compare_field("entry_count", 32'(want.count), 32'(entry_count_o));
        end
      end
      if (in_valid && !in_stall_o) begin
        predicted = apply_to_table(op_in, key_in, idx_in, value_in);
        pending.push_back(drive_typed ? drive_answer : predicted);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t   script[$];
    traffic_mix_e  plan[13];
    traffic_mix_e  mix;
    int            ins_pct;
    int            rem_pct;
    int            lkp_pct;
    int            r;
    op_e           op;
    logic [KEY_W-1:0]    key;
    logic [IDX_IN_W-1:0] idx;

    foreach (map_slot[i]) map_slot[i] = '0;
    foreach (slot_key[i]) slot_key[i] = '0;
    foreach (slot_word[i]) slot_word[i] = '0;

    // Empty table, extreme ids, stale map entries and the remove-swap paths.
    script.push_back(script_row(OP_LOOKUP, 0, 0, '0, 1, STS_ABSENT, 0, 0, '0, 0));
    script.push_back(script_row(OP_READ_SLOT, 0, 0, '0, 1, STS_RANGE, 0, 0, '0, 0));
    script.push_back(script_row(OP_READ_SLOT, 0, 255, '0, 1, STS_RANGE, 0, 255, '0, 0));
    script.push_back(script_row(OP_REMOVE, 1023, 0, '0, 1, STS_ABSENT, 1023, 0, '0, 0));
    script.push_back(script_row(OP_INSERT, 0, 0, '0, 1, STS_OK, 0, 0, '0, 1));
    script.push_back(script_row(OP_INSERT, 1023, 255, 32'hFFFF_FFFF,
                                1, STS_OK, 1023, 1, 32'hFFFF_FFFF, 2));
    script.push_back(script_row(OP_INSERT, 0, 0, 32'h1234_5678,
                                1, STS_PRESENT, 0, 0, '0, 2));
    script.push_back(script_row(OP_INSERT, 512, 0, 32'hA5A5_A5A5,
                                1, STS_OK, 512, 2, 32'hA5A5_A5A5, 3));
    script.push_back(script_row(OP_LOOKUP, 1023, 0, '0,
                                1, STS_OK, 1023, 1, 32'hFFFF_FFFF, 3));
    script.push_back(script_row(OP_READ_SLOT, 0, 2, '0,
                                1, STS_OK, 512, 2, 32'hA5A5_A5A5, 3));
    script.push_back(script_row(OP_READ_SLOT, 0, 3, '0, 1, STS_RANGE, 0, 3, '0, 3));
    script.push_back(script_row(OP_REMOVE, 0, 0, '0, 1, STS_OK, 0, 0, '0, 2));
    script.push_back(script_row(OP_LOOKUP, 512, 0, '0,
                                1, STS_OK, 512, 0, 32'hA5A5_A5A5, 2));
    // The map still points id 0 at slot 0, but the back-pointer now disagrees.
    script.push_back(script_row(OP_LOOKUP, 0, 0, '0, 1, STS_ABSENT, 0, 0, '0, 2));
    script.push_back(script_row(OP_READ_SLOT, 0, 0, '0));
    script.push_back(script_row(OP_REMOVE, 512, 0, '0,
                                1, STS_OK, 512, 0, 32'hA5A5_A5A5, 1));
    // Removing the only entry moves it onto itself.
    script.push_back(script_row(OP_REMOVE, 1023, 0, '0,
                                1, STS_OK, 1023, 0, 32'hFFFF_FFFF, 0));
    script.push_back(script_row(OP_LOOKUP, 1023, 0, '0, 1, STS_ABSENT, 1023, 0, '0, 0));
    script.push_back(script_row(OP_INSERT, 1023, 0, 32'h5555_5555));
    script.push_back(script_row(OP_INSERT, 341, 170, 32'hAAAA_AAAA));
    script.push_back(script_row(OP_READ_SLOT, 0, 255, '0));
    script.push_back(script_row(OP_REMOVE, 7, 0, '0));
    script.push_back(script_row(OP_LOOKUP, 341, 0, '0));

    // Fill to capacity, sit at full, drain to empty, and do it again.
    plan = '{MIX_GROW, MIX_GROW, MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_SHRINK,
             MIX_SHRINK, MIX_GROW, MIX_GROW, MIX_GROW, MIX_BALANCED, MIX_SHRINK,
             MIX_SHRINK};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      drive_item(script[i].op, script[i].key, script[i].idx, script[i].value,
                 script[i].typed, script[i].answer);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mix = plan[(n / SEGMENT_LEN) % 13];
      case (mix)
        MIX_GROW:     begin ins_pct = 90; rem_pct = 93; lkp_pct = 97; end
        MIX_BALANCED: begin ins_pct = 30; rem_pct = 60; lkp_pct = 80; end
        default:      begin ins_pct = 5;  rem_pct = 85; lkp_pct = 93; end
      endcase
      r = $urandom_range(99);
      idx = IDX_IN_W'($urandom_range(255));
      if (r < ins_pct) begin
        op = OP_INSERT;
        key = pick_key(15);
      end else if (r < rem_pct) begin
        op = OP_REMOVE;
        key = pick_key(85);
      end else if (r < lkp_pct) begin
        op = OP_LOOKUP;
        key = pick_key(65);
      end else begin
        op = OP_READ_SLOT;
        key = KEY_W'($urandom_range(ID_SPACE - 1));
        if (live_entries != 0 && $urandom_range(99) < 70)
          idx = IDX_IN_W'($urandom_range(live_entries - 1));
      end
      drive_item(op, key, idx, pick_value(), 1'b0, '0);
    end

    in_valid = 1'b0;
    stall_pct = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
